@@ hdl/sps_pkg.sv @@
package sps_pkg;

    localparam int DEF_NUM_STACKS = 8;
    localparam int DEF_POOL_SIZE  = 64;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [2:0]         stack_index;
        logic signed [31:0] push_value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pop_value;
    } out_t;

    typedef struct packed {
        logic load;
        logic rd_top;
        logic rd_link;
        logic link_sel;
        logic exec_push;
        logic exec_pop;
    } cmd_t;

endpackage

@@ hdl/sps_ctrl.sv @@
module sps_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          op,
    output logic          busy,
    output sps_pkg::cmd_t cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_PUSH_EXEC,
        S_POP_LINK,
        S_POP_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    busy_next  = 1'b1;
                    state_next = (op == sps_pkg::OP_POP) ? S_POP_LINK : S_PUSH_EXEC;
                end
            end
            S_POP_LINK:
            begin
                state_next = S_POP_EXEC;
            end
            S_PUSH_EXEC, S_POP_EXEC:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        cmd.load      = accept;
        cmd.rd_top    = (state_reg == S_IDLE);
        cmd.rd_link   = (state_reg == S_IDLE) || (state_reg == S_POP_LINK);
        cmd.link_sel  = (state_reg == S_POP_LINK);
        cmd.exec_push = (state_reg == S_PUSH_EXEC);
        cmd.exec_pop  = (state_reg == S_POP_EXEC);
    end

    assign busy = busy_reg;

endmodule

@@ hdl/sps_dpath.sv @@
module sps_dpath
#(
    parameter int NUM_STACKS = sps_pkg::DEF_NUM_STACKS,
    parameter int POOL_SIZE  = sps_pkg::DEF_POOL_SIZE
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  sps_pkg::in_t  item,
    input  sps_pkg::cmd_t cmd,
    output logic          done,
    output sps_pkg::out_t result
);

    localparam int PTR_W = $clog2(POOL_SIZE + 1);
    localparam int AW    = $clog2(POOL_SIZE);
    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_SIZE);

    logic signed [31:0] slot_data_mem [POOL_SIZE];
    logic [PTR_W-1:0]   slot_link_mem [POOL_SIZE];
    logic [PTR_W-1:0]   stack_top_mem [NUM_STACKS];

    sps_pkg::in_t       item_reg;
    logic [PTR_W-1:0]   free_head_reg;
    logic [PTR_W-1:0]   fill_reg;
    logic [NUM_STACKS-1:0] top_vld_reg;
    logic [PTR_W-1:0]   top_q_reg;
    logic               top_hit_reg;
    logic [PTR_W-1:0]   link_q_reg;
    logic [PTR_W-1:0]   link_alt_reg;
    logic               link_fresh_reg;
    logic signed [31:0] data_q_reg;
    logic               done_reg;
    sps_pkg::out_t      result_reg;

    logic [SW+2:0]      idx_in_ext;
    logic [SW+2:0]      idx_q_ext;
    logic [SW-1:0]      idx_in;
    logic [SW-1:0]      idx_q;
    logic               oob;
    logic [PTR_W-1:0]   top_eff;
    logic [PTR_W-1:0]   link_eff;
    logic [PTR_W-1:0]   link_addr;
    logic               push_ok;
    logic               pop_ok;
    logic               link_we;
    logic [PTR_W-1:0]   link_wa;
    logic [PTR_W-1:0]   link_wd;
    logic               top_we;
    logic [PTR_W-1:0]   top_wd;

    assign idx_in_ext = {SW'(0), item.stack_index};
    assign idx_q_ext  = {SW'(0), item_reg.stack_index};
    assign idx_in     = idx_in_ext[SW-1:0];
    assign idx_q      = idx_q_ext[SW-1:0];
    assign oob        = (32'(item_reg.stack_index) >= NUM_STACKS);

    assign top_eff    = top_hit_reg ? top_q_reg : NIL;
    // the link memory is not reset: slots at or beyond the fill mark take the next slot as their link
    assign link_eff   = link_fresh_reg ? link_alt_reg : link_q_reg;
    assign link_addr  = cmd.link_sel ? top_eff : free_head_reg;

    assign push_ok = cmd.exec_push && !oob && (free_head_reg != NIL);
    assign pop_ok  = cmd.exec_pop && !oob && (top_eff != NIL);

    assign link_we = push_ok || pop_ok;
    assign link_wa = push_ok ? free_head_reg : top_eff;
    assign link_wd = push_ok ? top_eff : free_head_reg;
    assign top_we  = push_ok || pop_ok;
    assign top_wd  = push_ok ? free_head_reg : link_eff;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.rd_top)
        begin
            top_q_reg   <= stack_top_mem[idx_in];
            top_hit_reg <= top_vld_reg[idx_in];
        end
        if (cmd.rd_link)
        begin
            link_q_reg     <= slot_link_mem[link_addr[AW-1:0]];
            data_q_reg     <= slot_data_mem[link_addr[AW-1:0]];
            link_alt_reg   <= link_addr + PTR_W'(1);
            link_fresh_reg <= (link_addr >= fill_reg);
        end
        if (push_ok)
        begin
            slot_data_mem[free_head_reg[AW-1:0]] <= item_reg.push_value;
        end
        if (link_we)
        begin
            slot_link_mem[link_wa[AW-1:0]] <= link_wd;
        end
        if (top_we)
        begin
            stack_top_mem[idx_q] <= top_wd;
        end
        if (cmd.exec_push || cmd.exec_pop)
        begin
            if (cmd.exec_push)
            begin
                result_reg.status <= push_ok ? sps_pkg::ST_OK : sps_pkg::ST_FULL;
            end
            else
            begin
                result_reg.status <= pop_ok ? sps_pkg::ST_OK : sps_pkg::ST_EMPTY;
            end
            result_reg.pop_value <= pop_ok ? data_q_reg : 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fill_reg      <= '0;
            top_vld_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec_push || cmd.exec_pop;
            if (push_ok)
            begin
                free_head_reg      <= link_eff;
                top_vld_reg[idx_q] <= 1'b1;
                if (free_head_reg >= fill_reg)
                begin
                    fill_reg <= free_head_reg + PTR_W'(1);
                end
            end
            else if (pop_ok)
            begin
                free_head_reg <= top_eff;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/shared_pool_multi_stack_top.sv @@
// Shared-pool multi-stack: NUM_STACKS stacks share POOL_SIZE slots via a
// linked free list.
//
// Command channel: an item (operation, stack_index, push_value) is taken at
// a rising edge with start high and busy low. busy stays high until the
// item has executed.
// Result channel: done is high for one cycle with status and pop_value on
// result. The receiver cannot stall; every result is taken in that cycle.
//
// Sequencing: a push goes through the exec state and a pop through the link
// and exec states, set by the dependent reads of the top-pointer memory and then
// the slot link/data memories. A new item can be accepted in the same cycle
// that done is shown, not earlier, since busy is high until then.
//
// Reset: all stacks empty, free list at slot 0. The link memory is not
// swept; a fill mark stands in for the initial slot-to-next links, so the
// block accepts items on the first cycle after reset.
module shared_pool_multi_stack_top
#(
    parameter int NUM_STACKS = sps_pkg::DEF_NUM_STACKS,
    parameter int POOL_SIZE  = sps_pkg::DEF_POOL_SIZE
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sps_pkg::in_t  item,
    output logic          busy,
    output logic          done,
    output sps_pkg::out_t result
);

    sps_pkg::cmd_t cmd;

    sps_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.operation),
        .busy  (busy),
        .cmd   (cmd)
    );

    sps_dpath
    #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_SIZE  (POOL_SIZE)
    )
    u_dpath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation == sps_pkg::OP_PUSH) |-> ##2 done)
        else $error("push result beat missing");

    a_pop_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation == sps_pkg::OP_POP) |-> ##3 done)
        else $error("pop result beat missing");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != sps_pkg::ST_OK) |-> (result.pop_value == 32'sd0))
        else $error("failed item returned nonzero value");

endmodule
